// ===== sv/pame_pkg.sv =====
// Package for the POCSAG alphanumeric page encoder.
// Holds word constants, field widths and the BCH unit request/response types.
// No dependencies.
package pame_pkg;

    // Field widths
    localparam int ADDR_BITS = 21;
    localparam int CHAR_BITS = 7;
    localparam int WORD_BITS = 20;   // text bits per message codeword
    localparam int DATA_BITS = 21;   // codeword data bits
    localparam int BCH_BITS  = 10;
    localparam int CW_BITS   = 32;

    // Batch length is fixed by the air format
    localparam int BATCH_WORDS = 16;

    // Default header length
    localparam int PAME_PREAMBLE_WORDS = 18;

    // Fixed words
    localparam logic [CW_BITS-1:0] PREAMBLE_WORD = 32'hAAAA_AAAA;
    localparam logic [CW_BITS-1:0] SYNC_WORD     = 32'h7CD2_15D8;
    localparam logic [CW_BITS-1:0] IDLE_WORD     = 32'h7A89_C197;

    // Generator x^10+x^9+x^8+x^6+x^5+x^3+1 without the x^10 term
    localparam logic [BCH_BITS-1:0] BCH_POLY = 10'h369;

    // Operation codes
    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_END  = 1'b1;

    // Request to the serial BCH unit
    typedef struct packed {
        logic                 start;
        logic [DATA_BITS-1:0] data;
    } t_bch_req;

    // Response from the serial BCH unit
    typedef struct packed {
        logic               done;
        logic [CW_BITS-1:0] word;
    } t_bch_rsp;

endpackage

// ===== sv/pame_if.sv =====
// Handshake interfaces for the POCSAG alphanumeric page encoder.
// Text/end beats in, codeword beats out, address register writes.
// Depends on pame_pkg.
interface pame_in_if import pame_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 operation;
    logic [CHAR_BITS-1:0] character;

    modport source (output valid, output operation, output character, input ready);
    modport sink   (input valid, input operation, input character, output ready);
endinterface

interface pame_out_if import pame_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CW_BITS-1:0] codeword;
    logic               last;

    modport source (output valid, output codeword, output last, input ready);
    modport sink   (input valid, input codeword, input last, output ready);
endinterface

interface pame_cfg_if import pame_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [ADDR_BITS-1:0] pager_address;

    modport source (output valid, output pager_address, input ready);
    modport sink   (input valid, input pager_address, output ready);
endinterface

// ===== sv/pame_bch.sv =====
// Bit-serial BCH(31,21) encoder with even parity, one data bit per cycle.
// Takes a 21-bit data word, then raises done with the 32-bit codeword.
// Depends on pame_pkg.
module pame_bch import pame_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_bch_req i_req,
    output t_bch_rsp o_rsp
);

    localparam int STEP_W = $clog2(DATA_BITS);

    logic                 r_busy;
    logic                 r_have;
    logic [DATA_BITS-1:0] r_sh;
    logic [BCH_BITS-1:0]  r_rem;
    logic                 r_par;
    logic [STEP_W-1:0]    r_step;

    logic                 n_fb;
    logic [BCH_BITS-1:0]  n_rem;

    // LFSR division step on the data MSB
    always_comb begin
        n_fb  = r_sh[DATA_BITS-1] ^ r_rem[BCH_BITS-1];
        n_rem = {r_rem[BCH_BITS-2:0], 1'b0} ^ (n_fb ? BCH_POLY : '0);
    end

    // Control and data path; data rotates so it is whole again when done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_have <= 1'b0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_have <= 1'b0;
            r_sh   <= i_req.data;
            r_rem  <= '0;
            r_par  <= 1'b0;
            r_step <= '0;
        end else if (r_busy) begin
            r_sh   <= {r_sh[DATA_BITS-2:0], r_sh[DATA_BITS-1]};
            r_rem  <= n_rem;
            r_par  <= r_par ^ r_sh[DATA_BITS-1];
            r_step <= r_step + 1'b1;
            if (r_step == STEP_W'(DATA_BITS - 1)) begin
                r_busy <= 1'b0;
                r_have <= 1'b1;
            end
        end
    end

    assign o_rsp.done = r_have & ~r_busy & ~i_req.start;
    assign o_rsp.word = {r_sh, r_rem, r_par ^ (^r_rem)};

endmodule

// ===== sv/pocsag_alpha_message_encoder_top.sv =====
// Top level of the POCSAG alphanumeric page encoder.
// Sequencer for header, text bit packing and batch framing; uses pame_bch.
// Depends on pame_pkg and the interfaces in pame_if.
//
//  channel  | dir | payload                    | notes
//  ---------+-----+----------------------------+--------------------------------
//  i_msg    | in  | operation, character       | one beat per char or end
//  o_word   | out | codeword, last             | last marks final word of a beat
//  i_cfg    | in  | pager_address              | always ready
//
// One input beat at a time. Characters pack one bit per cycle, pausing while a
// full word is encoded and sent; a codeword holds the sequencer for BCH start,
// serial steps and output load. Header: preamble, sync, pad idles, address word.
// End beat: zero alignment and a flush codeword if text is pending, a sync word
// if that fills the batch, up to 16 idles at one per cycle unless output stalls.
// A stalled output holds the sequencer at the next word. Reset is synchronous,
// and the block is ready for a beat in the cycle after reset.
module pocsag_alpha_message_encoder_top import pame_pkg::*; #(
    parameter int PREAMBLE_WORDS = PAME_PREAMBLE_WORDS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pame_in_if.sink     i_msg,
    pame_out_if.source  o_word,
    pame_cfg_if.sink    i_cfg
);

    localparam int PRE_W  = $clog2(PREAMBLE_WORDS + 1);
    localparam int POS_W  = $clog2(BATCH_WORDS);
    localparam int CNT_W  = $clog2(WORD_BITS + 1);
    localparam int LEFT_W = $clog2(CHAR_BITS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_PRE, S_HSYNC, S_PAD, S_ENC, S_BSYNC, S_BITS, S_ALIGN, S_END_IDLE
    } t_state;

    typedef enum logic [1:0] {
        K_ADDR, K_DATA, K_FLUSH
    } t_kind;

    t_state               r_state;
    t_kind                r_kind;
    logic                 r_in_msg;
    logic [WORD_BITS-1:0] r_acc;
    logic [CNT_W-1:0]     r_cnt;
    logic [POS_W-1:0]     r_pos;
    logic [PRE_W-1:0]     r_pre;
    logic [3:0]           r_pad;
    logic [CHAR_BITS-1:0] r_char;
    logic [LEFT_W-1:0]    r_bits_left;
    logic [ADDR_BITS-1:0] r_pager_address;
    logic                 r_bch_start;
    logic [DATA_BITS-1:0] r_bch_data;
    logic                 r_out_valid;
    logic [CW_BITS-1:0]   r_codeword;
    logic                 r_last;

    t_bch_req             bch_req;
    t_bch_rsp             bch_rsp;
    logic                 msg_beat;
    logic                 out_free;
    logic [WORD_BITS-1:0] n_acc;
    logic [DATA_BITS-1:0] addr_data;

    assign msg_beat  = i_msg.valid & i_msg.ready;
    assign out_free  = ~r_out_valid | o_word.ready;
    assign n_acc     = {r_acc[WORD_BITS-2:0], r_char[0]};
    assign addr_data = {1'b0, r_pager_address[ADDR_BITS-1:3], 2'b11};

    assign bch_req.start = r_bch_start;
    assign bch_req.data  = r_bch_data;

    pame_bch u_bch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (bch_req),
        .o_rsp   (bch_rsp)
    );

    // Sequencer, framing state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_kind          <= K_DATA;
            r_in_msg        <= 1'b0;
            r_acc           <= '0;
            r_cnt           <= '0;
            r_pos           <= '0;
            r_pager_address <= '0;
            r_bch_start     <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_bch_start <= 1'b0;
            if (o_word.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid) begin
                r_pager_address <= i_cfg.pager_address;
            end

            case (r_state)
                S_IDLE: begin
                    if (msg_beat) begin
                        r_char      <= i_msg.character;
                        r_bits_left <= LEFT_W'(CHAR_BITS);
                        if (i_msg.operation == OP_CHAR) begin
                            r_pre   <= '0;
                            r_state <= r_in_msg ? S_BITS : S_PRE;
                        end else if (r_in_msg) begin
                            r_state <= (r_cnt != '0) ? S_ALIGN : S_END_IDLE;
                        end
                    end
                end

                // Preamble words
                S_PRE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_codeword  <= PREAMBLE_WORD;
                        r_last      <= 1'b0;
                        r_pre       <= r_pre + 1'b1;
                        if (r_pre == PRE_W'(PREAMBLE_WORDS - 1)) begin
                            r_state <= S_HSYNC;
                        end
                    end
                end

                // First sync, then idles up to the pager's frame
                S_HSYNC: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_codeword  <= SYNC_WORD;
                        r_last      <= 1'b0;
                        r_pad       <= {r_pager_address[2:0], 1'b0};
                        if (r_pager_address[2:0] == 3'd0) begin
                            r_bch_start <= 1'b1;
                            r_bch_data  <= addr_data;
                            r_kind      <= K_ADDR;
                            r_state     <= S_ENC;
                        end else begin
                            r_state <= S_PAD;
                        end
                    end
                end

                S_PAD: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_codeword  <= IDLE_WORD;
                        r_last      <= 1'b0;
                        r_pad       <= r_pad - 1'b1;
                        if (r_pad == 4'd1) begin
                            r_bch_start <= 1'b1;
                            r_bch_data  <= addr_data;
                            r_kind      <= K_ADDR;
                            r_state     <= S_ENC;
                        end
                    end
                end

                // Wait for the encoded word, then send it
                S_ENC: begin
                    if (bch_rsp.done && out_free) begin
                        r_out_valid <= 1'b1;
                        r_codeword  <= bch_rsp.word;
                        case (r_kind)
                            K_ADDR: begin
                                r_last   <= 1'b1;
                                r_pos    <= {r_pager_address[2:0], 1'b1};
                                r_in_msg <= 1'b1;
                                r_acc    <= '0;
                                r_cnt    <= '0;
                                r_state  <= S_BITS;
                            end
                            K_DATA: begin
                                r_last <= (r_pos != POS_W'(BATCH_WORDS - 1));
                                r_pos  <= r_pos + 1'b1;
                                if (r_pos == POS_W'(BATCH_WORDS - 1)) begin
                                    r_state <= S_BSYNC;
                                end else begin
                                    r_state <= (r_bits_left != '0) ? S_BITS : S_IDLE;
                                end
                            end
                            default: begin
                                r_last  <= 1'b0;
                                r_pos   <= r_pos + 1'b1;
                                r_state <= (r_pos == POS_W'(BATCH_WORDS - 1)) ?
                                           S_BSYNC : S_END_IDLE;
                            end
                        endcase
                    end
                end

                // Sync word after a full batch
                S_BSYNC: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_codeword  <= SYNC_WORD;
                        r_last      <= (r_kind == K_DATA);
                        if (r_kind == K_FLUSH) begin
                            r_state <= S_END_IDLE;
                        end else begin
                            r_state <= (r_bits_left != '0) ? S_BITS : S_IDLE;
                        end
                    end
                end

                // Pack one text bit per cycle, LSB of the character first
                S_BITS: begin
                    r_char      <= r_char >> 1;
                    r_bits_left <= r_bits_left - 1'b1;
                    if (r_cnt == CNT_W'(WORD_BITS - 1)) begin
                        r_bch_start <= 1'b1;
                        r_bch_data  <= {1'b1, n_acc};
                        r_acc       <= '0;
                        r_cnt       <= '0;
                        r_kind      <= K_DATA;
                        r_state     <= S_ENC;
                    end else begin
                        r_acc <= n_acc;
                        r_cnt <= r_cnt + 1'b1;
                        if (r_bits_left == LEFT_W'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end

                // Zero-pad the remainder up to a full word, one bit per cycle
                S_ALIGN: begin
                    if (r_cnt == CNT_W'(WORD_BITS)) begin
                        r_bch_start <= 1'b1;
                        r_bch_data  <= {1'b1, r_acc};
                        r_acc       <= '0;
                        r_cnt       <= '0;
                        r_kind      <= K_FLUSH;
                        r_state     <= S_ENC;
                    end else begin
                        r_acc <= {r_acc[WORD_BITS-2:0], 1'b0};
                        r_cnt <= r_cnt + 1'b1;
                    end
                end

                // Closing idle, then idles to the batch end
                S_END_IDLE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_codeword  <= IDLE_WORD;
                        r_last      <= (r_pos == POS_W'(BATCH_WORDS - 1));
                        r_pos       <= r_pos + 1'b1;
                        if (r_pos == POS_W'(BATCH_WORDS - 1)) begin
                            r_in_msg <= 1'b0;
                            r_acc    <= '0;
                            r_cnt    <= '0;
                            r_state  <= S_IDLE;
                        end
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_msg.ready     = (r_state == S_IDLE);
    assign i_cfg.ready     = 1'b1;
    assign o_word.valid    = r_out_valid;
    assign o_word.codeword = r_codeword;
    assign o_word.last     = r_last;

    // Pending text never holds a full word outside alignment
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_ALIGN) |-> (r_cnt < CNT_W'(WORD_BITS)))
        else $error("text bit count out of range");

    // An end beat with no open page leaves the sequencer idle
    a_end_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (msg_beat && i_msg.operation == OP_END && !r_in_msg) |=> (r_state == S_IDLE))
        else $error("end beat without page was not ignored");

    // The final padding word closes the page and the batch
    a_page_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_END_IDLE && out_free && r_pos == POS_W'(BATCH_WORDS - 1))
        |=> (!r_in_msg && r_pos == '0 && r_state == S_IDLE))
        else $error("page not closed at batch end");

    // Bit packing runs only with character bits left
    a_bits_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BITS) |-> (r_bits_left != '0))
        else $error("bit packing with no bits left");

endmodule
